// ===== rtl/core/khcc_pkg.sv =====
// Shared types and constants for the keyed hop command check block.
package khcc_pkg;

    localparam logic [31:0] FNV_OFFSET    = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME     = 32'd16777619;
    localparam logic [31:0] KEY_RESET     = 32'h6a09e667;
    localparam logic [7:0]  VERSION_RESET = 8'd1;
    localparam logic [7:0]  COMMAND_RESET = 8'd1;
    localparam logic [7:0]  CHANNEL_RESET = 8'd129;

    // Bytes fed through the hash: 4 key, 4 header, 4 stamp, 4 zeroed tag
    localparam int unsigned HASH_BYTES = 16;
    localparam int unsigned HASH_CNT_W = $clog2(HASH_BYTES);

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_LEN = 2'd1,
        STATUS_BAD_HDR = 2'd2,
        STATUS_BAD_MAC = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_MAC_KEY     = 2'd0,
        REG_EXP_VERSION = 2'd1,
        REG_HOP_COMMAND = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_HASH = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hash_status_t;

endpackage

// ===== rtl/core/keyed_hop_command_check_top.sv =====
// Keyed hop command check: header checks, keyed FNV-1a MAC, channel adoption.
//
// One message at a time. A message that passes the length, version and command
// checks is hashed one byte per cycle through a single 32x32 FNV multiply
// (4 key bytes, 12 message bytes with the tag zeroed). Once all 16 bytes are
// hashed, the tag is compared in the hash state and the result is loaded into
// the output register from the done state. A message that fails the header
// checks skips the hash and goes straight to the done state. The input stays
// stalled until the result is loaded, so no new message is taken while the
// previous one is still in flight. A new message is
// taken as soon as the previous result is loaded into the output register, even
// if that result is still stalled; a result that cannot be loaded waits for the
// output and holds the input stalled. The config port never stalls; write it
// only while no message is in flight.
module keyed_hop_command_check_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  khcc_pkg::cfg_index_t     cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     length_ok,
    input  logic [7:0]               version,
    input  logic [7:0]               command,
    input  logic [7:0]               target_channel,
    input  logic [7:0]               spare_byte,
    input  logic [31:0]              stamp,
    input  logic [31:0]              tag,
    output logic                     out_valid,
    input  logic                     out_stall,
    output khcc_pkg::status_t        status,
    output logic                     switched,
    output logic [7:0]               channel_out
);
    import khcc_pkg::*;

    logic [31:0]      mac_key_reg;
    logic [7:0]       exp_version_reg;
    logic [7:0]       hop_command_reg;

    state_t           state_reg, state_next;
    status_t          res_status_reg, res_status_next;
    logic [7:0]       target_reg;
    logic [31:0]      tag_reg;
    logic [7:0]       channel_now_reg, channel_now_next;
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic             switched_reg, switched_next;

    logic             in_accept;
    logic             out_free;
    logic             out_load;
    logic             hash_start;
    hash_status_t     hash_stat;
    logic [31:0]      hash_value;
    logic [HASH_BYTES*8-1:0] hash_msg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_key_reg     <= KEY_RESET;
            exp_version_reg <= VERSION_RESET;
            hop_command_reg <= COMMAND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAC_KEY:     mac_key_reg     <= cfg_data;
                REG_EXP_VERSION: exp_version_reg <= cfg_data[7:0];
                REG_HOP_COMMAND: hop_command_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // low byte of the vector is hashed first
    assign hash_msg = {32'd0, stamp, spare_byte, target_channel, command, version,
                       mac_key_reg};

    khcc_fnv_unit u_fnv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .msg   (hash_msg),
        .stat  (hash_stat),
        .hash  (hash_value)
    );

    always_comb
    begin
        state_next       = state_reg;
        res_status_next  = res_status_reg;
        hash_start       = 1'b0;
        out_load         = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        switched_next    = switched_reg;
        channel_now_next = channel_now_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!length_ok)
                    begin
                        res_status_next = STATUS_BAD_LEN;
                        state_next      = ST_DONE;
                    end
                    else if (version != exp_version_reg || command != hop_command_reg)
                    begin
                        res_status_next = STATUS_BAD_HDR;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_stat.done)
                begin
                    res_status_next = (hash_value == tag_reg) ? STATUS_OK : STATUS_BAD_MAC;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    switched_next  = (res_status_reg == STATUS_OK)
                                     && (target_reg != channel_now_reg);
                    if (res_status_reg == STATUS_OK)
                        channel_now_next = target_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            channel_now_reg <= CHANNEL_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            channel_now_reg <= channel_now_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        status_reg     <= status_next;
        switched_reg   <= switched_next;
        if (in_accept)
        begin
            target_reg <= target_channel;
            tag_reg    <= tag;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign switched    = switched_reg;
    assign channel_out = channel_now_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        hash_stat.done |-> state_reg == ST_HASH)
        else $error("hash finished outside the hash state");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared without a finished item");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(channel_now_reg) |-> $past(out_load) && $past(res_status_reg) == STATUS_OK)
        else $error("channel changed without an accepted message");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && switched_reg |-> status_reg == STATUS_OK)
        else $error("switch flagged on a rejected message");

endmodule

// ===== rtl/core/khcc_fnv_unit.sv =====
// Iterative FNV-1a engine: one message byte and one multiply per cycle.
module khcc_fnv_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [khcc_pkg::HASH_BYTES*8-1:0]    msg,
    output khcc_pkg::hash_status_t               stat,
    output logic [31:0]                          hash
);
    import khcc_pkg::*;

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [HASH_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [HASH_BYTES*8-1:0]    shift_reg, shift_next;
    logic [31:0]                hash_reg, hash_next;
    logic [31:0]                mixed;

    // byte 0 sits at the low end; shift right one byte per step
    assign mixed = hash_reg ^ {24'd0, shift_reg[7:0]};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        hash_next  = hash_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = msg;
            hash_next  = FNV_OFFSET;
        end
        else if (busy_reg)
        begin
            hash_next  = 32'(mixed * FNV_PRIME);
            shift_next = {8'd0, shift_reg[HASH_BYTES*8-1:8]};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == HASH_CNT_W'(HASH_BYTES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        hash_reg  <= hash_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign hash      = hash_reg;

    // a finished pass must have stepped through the last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("hash done without a completed pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == '0)
        else $error("hash start did not load the engine");

    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == '0 || cnt_reg == HASH_CNT_W'(HASH_BYTES - 1) + 1'b1
                      || $past(start) == 1'b0)
        else $error("step counter moved while idle");

endmodule

// ===== verif/keyed_hop_command_check_top_tb.sv =====
// Testbench for the keyed hop command check block: queued driver, monitor and scoreboard.
`timescale 1ns / 100ps

module keyed_hop_command_check_top_tb;
    import khcc_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 8;
    localparam int RAND_ITEMS  = 198;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic        length_ok;
        logic [7:0]  version;
        logic [7:0]  command;
        logic [7:0]  target_channel;
        logic [7:0]  spare_byte;
        logic [31:0] stamp;
        logic [31:0] tag;
    } hop_msg_t;

    typedef struct packed {
        status_t    status;
        logic       switched;
        logic [7:0] channel;
    } hop_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = REG_MAC_KEY;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    status_t     status;
    logic        switched;
    logic [7:0]  channel_out;

    hop_msg_t    drv_msg = '0;
    wire         length_ok      = drv_msg.length_ok;
    wire [7:0]   version        = drv_msg.version;
    wire [7:0]   command        = drv_msg.command;
    wire [7:0]   target_channel = drv_msg.target_channel;
    wire [7:0]   spare_byte     = drv_msg.spare_byte;
    wire [31:0]  stamp          = drv_msg.stamp;
    wire [31:0]  tag            = drv_msg.tag;

    // Predictor copy of registers and channel state
    logic [31:0] cfg_key     = KEY_RESET;
    logic [7:0]  cfg_version = VERSION_RESET;
    logic [7:0]  cfg_command = COMMAND_RESET;
    logic [7:0]  channel_now = CHANNEL_RESET;

    hop_msg_t     pending_msgs[$];
    hop_verdict_t awaited_verdicts[$];

    int   errors = 0;
    int   cycles = 0;
    logic in_took = 1'b0;
    int   stall_pct = 0;
    int   max_gap = 0;
    int   max_burst = 8;
    int   hold_asks = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   gap_left = 0;
    int   burst_left = 1;

    keyed_hop_command_check_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .length_ok      (length_ok),
        .version        (version),
        .command        (command),
        .target_channel (target_channel),
        .spare_byte     (spare_byte),
        .stamp          (stamp),
        .tag            (tag),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .switched       (switched),
        .channel_out    (channel_out)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Keyed FNV-1a: key bytes low first, then the 12 message bytes with the tag as zeros
    function automatic logic [31:0] hop_mac(input logic [31:0] key, input hop_msg_t m);
        logic [127:0] stream;
        logic [31:0]  h;
        stream = {32'h0, m.stamp, m.spare_byte, m.target_channel, m.command, m.version, key};
        h = FNV_OFFSET;
        for (int i = 0; i < 16; i++)
            h = (h ^ {24'h0, stream[8*i +: 8]}) * FNV_PRIME;
        return h;
    endfunction

    task automatic judge_message(input hop_msg_t m);
        hop_verdict_t v;
        v.switched = 1'b0;
        if (!m.length_ok)
            v.status = STATUS_BAD_LEN;
        else if (m.version != cfg_version || m.command != cfg_command)
            v.status = STATUS_BAD_HDR;
        else if (hop_mac(cfg_key, m) != m.tag)
            v.status = STATUS_BAD_MAC;
        else
        begin
            v.status = STATUS_OK;
            if (m.target_channel != channel_now)
            begin
                v.switched  = 1'b1;
                channel_now = m.target_channel;
            end
        end
        v.channel = channel_now;
        awaited_verdicts.push_back(v);
    endtask

    // seal set: tag is the true MAC xor tag_bits; otherwise tag_bits as given
    task automatic queue_msg(input logic ok, input logic [7:0] ver, input logic [7:0] cmd,
                             input logic [7:0] chan, input logic [7:0] spare,
                             input logic [31:0] st, input logic seal,
                             input logic [31:0] tag_bits);
        hop_msg_t m;
        m.length_ok      = ok;
        m.version        = ver;
        m.command        = cmd;
        m.target_channel = chan;
        m.spare_byte     = spare;
        m.stamp          = st;
        m.tag            = seal ? (hop_mac(cfg_key, m) ^ tag_bits) : tag_bits;
        pending_msgs.push_back(m);
    endtask

    // Mostly well-formed sealed messages; the rest broken in one way or another
    function automatic hop_msg_t random_message();
        hop_msg_t m;
        int       pick;
        m.length_ok      = 1'b1;
        m.version        = cfg_version;
        m.command        = cfg_command;
        m.target_channel = ($urandom_range(2) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
        m.spare_byte     = 8'($urandom);
        m.stamp          = $urandom;
        m.tag            = hop_mac(cfg_key, m);
        pick = $urandom_range(99);
        if (pick < 6)
            m.tag = m.tag ^ (32'h1 << $urandom_range(31));
        else if (pick < 10)
            m.tag = $urandom;
        else if (pick < 18)
        begin
            m.length_ok = 1'b0;
            if ($urandom_range(1) == 1)
            begin
                m.version = 8'($urandom);
                m.command = 8'($urandom);
            end
        end
        else if (pick < 30)
        begin
            if ($urandom_range(1) == 1)
                m.version = 8'($urandom);
            else
                m.command = 8'($urandom);
            if (m.version == cfg_version && m.command == cfg_command)
                m.command = m.command ^ 8'($urandom_range(1, 255));
        end
        return m;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MAC_KEY:     cfg_key     = val;
            REG_EXP_VERSION: cfg_version = val[7:0];
            REG_HOP_COMMAND: cfg_command = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (pending_msgs.size() != 0 || in_valid || awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Sender: bursts of items with random gaps in between
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_msgs.size() != 0)
            begin
                drv_msg = pending_msgs.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, max_burst);
                    gap_left   = $urandom_range(0, max_gap);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stall, plus a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_served != hold_asks)
        begin
            hold_served++;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor and scoreboard
    always @(posedge clk)
    begin
        hop_verdict_t exp_v;
        if (rst_n)
        begin
            cycles++;
            if (in_valid && !in_stall)
                judge_message(drv_msg);
            if (out_valid && !out_stall)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    $display("%0t: result with none expected: status %0d switched %0d channel %0d",
                             $time, status, switched, channel_out);
                    errors++;
                end
                else
                begin
                    exp_v = awaited_verdicts.pop_front();
                    if (status !== exp_v.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_v.status, status);
                        errors++;
                    end
                    if (switched !== exp_v.switched)
                    begin
                        $display("%0t: switched expected %0d actual %0d",
                                 $time, exp_v.switched, switched);
                        errors++;
                    end
                    if (channel_out !== exp_v.channel)
                    begin
                        $display("%0t: channel_out expected %0d actual %0d",
                                 $time, exp_v.channel, channel_out);
                        errors++;
                    end
                end
            end
            in_took <= in_valid && !in_stall;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] key_v;
        logic [7:0]  ver_v;
        logic [7:0]  cmd_v;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset register values
        stall_pct = 20;
        max_gap   = 2;
        queue_msg(1'b1, 8'd1, 8'd1, 8'd129, 8'h00, 32'h0, 1'b1, 32'h0);      // same channel
        queue_msg(1'b1, 8'd1, 8'd1, 8'd0, 8'hff, 32'hffffffff, 1'b1, 32'h0); // switch to 0
        queue_msg(1'b1, 8'd1, 8'd1, 8'd0, 8'hff, 32'hffffffff, 1'b1, 32'h0); // no switch
        queue_msg(1'b1, 8'd1, 8'd1, 8'd255, 8'h5a, 32'h80000001, 1'b1, 32'h0);
        queue_msg(1'b1, 8'd1, 8'd1, 8'd7, 8'h11, 32'h12345678, 1'b1, 32'h1); // one MAC bit off
        queue_msg(1'b1, 8'd1, 8'd1, 8'd7, 8'h11, 32'h12345678, 1'b0, 32'h0);
        queue_msg(1'b1, 8'd1, 8'd1, 8'd7, 8'h11, 32'h12345678, 1'b0, 32'hffffffff);
        queue_msg(1'b0, 8'd1, 8'd1, 8'd9, 8'h22, 32'h0badf00d, 1'b1, 32'h0); // length beats all
        queue_msg(1'b0, 8'd0, 8'd255, 8'd9, 8'h22, 32'h0badf00d, 1'b1, 32'h0);
        queue_msg(1'b1, 8'd0, 8'd1, 8'd9, 8'h00, 32'h0, 1'b1, 32'h0);
        queue_msg(1'b1, 8'd255, 8'd1, 8'd9, 8'h00, 32'h0, 1'b1, 32'h0);
        queue_msg(1'b1, 8'd1, 8'd0, 8'd9, 8'h00, 32'h0, 1'b1, 32'h0);
        queue_msg(1'b1, 8'd1, 8'd255, 8'd9, 8'h00, 32'h0, 1'b1, 32'h0);
        queue_msg(1'b1, 8'd2, 8'd2, 8'd9, 8'h00, 32'h0, 1'b1, 32'h0);        // header bad, MAC good
        queue_msg(1'b1, 8'd1, 8'd1, 8'd129, 8'ha5, 32'h12345678, 1'b1, 32'h0); // back to 129
        queue_msg(1'b0, 8'd1, 8'd1, 8'd0, 8'ha5, 32'h12345678, 1'b1, 32'h0);
        for (int i = 0; i < RAND_ITEMS; i++)
            pending_msgs.push_back(random_message());

        for (int phase = 1; phase < PHASES; phase++)
        begin
            wait_quiet();
            key_v = $urandom;
            ver_v = 8'($urandom);
            cmd_v = 8'($urandom);
            case (phase)
                1:
                begin
                    key_v = 32'h0; ver_v = 8'h00; cmd_v = 8'h00;
                    stall_pct = 0;  max_gap = 0;  max_burst = 30;
                end
                2:
                begin
                    key_v = 32'hffffffff; ver_v = 8'hff; cmd_v = 8'hff;
                    stall_pct = 30; max_gap = 6;  max_burst = 8;
                end
                3:
                begin
                    stall_pct = 20; max_gap = 0;  max_burst = 40;
                end
                4:
                begin
                    stall_pct = 85; max_gap = 10; max_burst = 4;
                end
                5:
                begin
                    cmd_v = ver_v;
                    stall_pct = 50; max_gap = 3;  max_burst = 12;
                end
                6:
                begin
                    stall_pct = 10; max_gap = 20; max_burst = 3;
                end
                default:
                begin
                    key_v = KEY_RESET; ver_v = VERSION_RESET; cmd_v = COMMAND_RESET;
                    stall_pct = 40; max_gap = 5;  max_burst = 16;
                end
            endcase
            write_reg(REG_MAC_KEY, key_v);
            write_reg(REG_EXP_VERSION, {24'h0, ver_v});
            write_reg(REG_HOP_COMMAND, {24'h0, cmd_v});
            for (int i = 0; i < RAND_ITEMS; i++)
                pending_msgs.push_back(random_message());
            // back up the output while the sender keeps offering items
            if (phase == 3)
                hold_asks++;
        end

        wait_quiet();
        if (errors == 0 && awaited_verdicts.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
